// ===== rtl/ipmb_pending_request_tracker_defines.svh =====
// ----------------------------------------------------------------------------
// IPMB pending request tracker: assertion macros
// Shared concurrent assertion shorthands, clocked on clk; IPT_ASSERT is disabled during rst.
// ----------------------------------------------------------------------------
`ifndef IPMB_PENDING_REQUEST_TRACKER_DEFINES_SVH
`define IPMB_PENDING_REQUEST_TRACKER_DEFINES_SVH

// checked only out of reset
`define IPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked also during reset
`define IPT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/ipt_pkg.sv =====
// ----------------------------------------------------------------------------
// IPMB pending request tracker package
// Shared widths, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ipt_pkg;

  localparam int NUM_ENTRIES_DEF = 256;
  localparam int SEQ_COUNT_DEF   = 64;

  localparam int KEY_W = 31;  // bcast, sa, lun, seq, netfn, cmd
  localparam int TAG_W = 48;  // msg tag, reply port
  localparam int TMR_W = 16;
  localparam int EXP_W = 9;

  localparam logic [5:0] REQ_NETFN_MASK = 6'h3E;
  localparam logic [5:0] RSP_NETFN_BIT  = 6'h01;

  localparam logic [15:0] TIMEOUT_LIMIT_RST   = 16'd5000;
  localparam logic [15:0] DEFAULT_TIMEOUT_RST = 16'd1000;
  localparam logic [15:0] TICK_PERIOD_RST     = 16'd100;
  localparam logic [7:0]  BROADCAST_ADDR_RST  = 8'd0;

  localparam logic [1:0] REG_TIMEOUT_LIMIT   = 2'd0;
  localparam logic [1:0] REG_DEFAULT_TIMEOUT = 2'd1;
  localparam logic [1:0] REG_TICK_PERIOD     = 2'd2;
  localparam logic [1:0] REG_BROADCAST_ADDR  = 2'd3;

  localparam logic [1:0] KIND_SEND = 2'd0;
  localparam logic [1:0] KIND_RSP  = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;
  localparam logic [1:0] KIND_NONE = 2'd3;

  localparam logic [2:0] ST_ACCEPTED  = 3'd0;
  localparam logic [2:0] ST_NO_ENTRY  = 3'd1;
  localparam logic [2:0] ST_NO_SEQ    = 3'd2;
  localparam logic [2:0] ST_MATCHED   = 3'd3;
  localparam logic [2:0] ST_UNMATCHED = 3'd4;
  localparam logic [2:0] ST_TICK      = 3'd5;
  localparam logic [2:0] ST_PASS      = 3'd6;

  typedef struct packed {
    logic start;
    logic scan;
    logic seq_step;
    logic commit;
    logic load_out;
  } ipt_cmd_t;

  typedef struct packed {
    logic in_pass;
    logic in_none;
    logic kind_send;
    logic free_found;
    logic scan_done;
    logic seq_free;
    logic seq_last;
    logic out_busy;
  } ipt_stat_t;

endpackage

// ===== rtl/ipt_ram.sv =====
// ----------------------------------------------------------------------------
// IPMB tracker generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ipt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/ipt_datapath.sv =====
// ----------------------------------------------------------------------------
// IPMB tracker datapath
// Item and config registers, entry table, scan pipeline, sequence search,
// result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ipt_datapath import ipt_pkg::*; #(
  parameter int NUM_ENTRIES = NUM_ENTRIES_DEF,
  parameter int SEQ_COUNT   = SEQ_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  ipt_cmd_t    cmd,
  output ipt_stat_t   st,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic [1:0]  kind,
  input  logic [7:0]  slave_addr,
  input  logic [1:0]  lun,
  input  logic [5:0]  net_fn,
  input  logic [7:0]  command,
  input  logic [5:0]  seq_in,
  input  logic [15:0] timeout_ms,
  input  logic [31:0] msg_tag,
  input  logic [15:0] reply_port,
  input  logic        out_stall,
  output logic        out_valid,
  output logic [2:0]  status,
  output logic [5:0]  seq_out,
  output logic [31:0] tag_out,
  output logic [15:0] port_out,
  output logic [EXP_W-1:0] expired_count
);

  localparam int IW  = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int CW  = $clog2(NUM_ENTRIES + 1);
  localparam int SQW = $clog2(SEQ_COUNT);
  localparam logic [CW-1:0]  CNT_END  = CW'(NUM_ENTRIES);
  localparam logic [5:0]     SEQ_MAX  = 6'(SEQ_COUNT - 1);
  localparam logic [SQW-1:0] SCNT_MAX = SQW'(SEQ_COUNT - 1);

  // config
  logic [15:0] timeout_limit, default_timeout, tick_period;
  logic [7:0]  broadcast_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_limit   <= TIMEOUT_LIMIT_RST;
      default_timeout <= DEFAULT_TIMEOUT_RST;
      tick_period     <= TICK_PERIOD_RST;
      broadcast_addr  <= BROADCAST_ADDR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TIMEOUT_LIMIT:   timeout_limit   <= cfg_data;
        REG_DEFAULT_TIMEOUT: default_timeout <= cfg_data;
        REG_TICK_PERIOD:     tick_period     <= cfg_data;
        REG_BROADCAST_ADDR:  broadcast_addr  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // item registers
  logic [1:0]  kind_r;
  logic        pass_r;
  logic [7:0]  sa_r;
  logic [1:0]  lun_r;
  logic [5:0]  nf_r;
  logic [7:0]  cmd_r;
  logic [5:0]  seq_r;
  logic [15:0] tmo_r;
  logic [31:0] tag_r;
  logic [15:0] port_r;
  logic [15:0] tmo_clamp, tmo_eff;

  assign tmo_clamp = (timeout_ms > timeout_limit) ? timeout_limit : timeout_ms;
  assign tmo_eff   = (tmo_clamp == 16'd0) ? default_timeout : tmo_clamp;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      kind_r <= kind;
      pass_r <= net_fn[0];
      sa_r   <= slave_addr;
      lun_r  <= lun;
      nf_r   <= net_fn & REQ_NETFN_MASK;
      cmd_r  <= command;
      seq_r  <= seq_in;
      tmo_r  <= tmo_eff;
      tag_r  <= msg_tag;
      port_r <= reply_port;
    end
  end

  // table
  logic [NUM_ENTRIES-1:0] valid;
  logic [CW-1:0]    cnt;
  logic             p_valid;
  logic [IW-1:0]    p_idx;
  logic [KEY_W-1:0] key_q;
  logic [TAG_W-1:0] tag_q;
  logic [TMR_W-1:0] tim_q;
  logic             v_p;
  logic             part_match, full_match, expire, tick_wr;

  logic             free_found, hit_found, hit_bcast, seq_found;
  logic [IW-1:0]    free_slot, hit_idx;
  logic [TAG_W-1:0] hit_tag;
  logic [SEQ_COUNT-1:0] used;
  logic [5:0]       seq_cand, next_seq, seq_inc;
  logic [SQW-1:0]   seq_cnt;
  logic [EXP_W-1:0] expired;
  logic             commit_acc, commit_free;

  assign v_p        = valid[p_idx];
  assign part_match = (key_q[29:22] == sa_r) && (key_q[21:20] == lun_r) &&
                      (key_q[13:8] == nf_r) && (key_q[7:0] == cmd_r);
  assign full_match = part_match && (key_q[19:14] == seq_r);
  assign expire     = (tim_q <= tick_period);
  assign tick_wr    = p_valid && (kind_r == KIND_TICK) && v_p && !expire;
  assign seq_inc    = (seq_cand == SEQ_MAX) ? 6'd0 : seq_cand + 6'd1;

  assign commit_acc  = cmd.commit && (kind_r == KIND_SEND) && !pass_r &&
                       free_found && seq_found;
  assign commit_free = cmd.commit && (kind_r == KIND_RSP) && hit_found && !hit_bcast;

  logic             ram_we_tmr;
  logic [IW-1:0]    waddr;
  logic [TMR_W-1:0] tmr_wdata;

  assign ram_we_tmr = commit_acc || tick_wr;
  assign waddr      = commit_acc ? free_slot : p_idx;
  assign tmr_wdata  = commit_acc ? tmo_r : tim_q - tick_period;

  ipt_ram #(.WIDTH(KEY_W), .DEPTH(NUM_ENTRIES)) u_key_ram (
    .clk(clk), .we(commit_acc), .waddr(waddr),
    .wdata({(sa_r == broadcast_addr), sa_r, lun_r, seq_cand, nf_r, cmd_r}),
    .raddr(cnt[IW-1:0]), .rdata(key_q)
  );

  ipt_ram #(.WIDTH(TAG_W), .DEPTH(NUM_ENTRIES)) u_tag_ram (
    .clk(clk), .we(commit_acc), .waddr(waddr), .wdata({tag_r, port_r}),
    .raddr(cnt[IW-1:0]), .rdata(tag_q)
  );

  ipt_ram #(.WIDTH(TMR_W), .DEPTH(NUM_ENTRIES)) u_tmr_ram (
    .clk(clk), .we(ram_we_tmr), .waddr(waddr), .wdata(tmr_wdata),
    .raddr(cnt[IW-1:0]), .rdata(tim_q)
  );

  // scan pipeline: address out of cnt, entry processed in the following cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      p_valid  <= 1'b0;
      next_seq <= 6'd0;
    end else begin
      p_valid <= cmd.scan && (cnt != CNT_END);
      if (p_valid && (kind_r == KIND_TICK) && v_p && expire) begin
        valid[p_idx] <= 1'b0;
      end
      if (commit_acc) begin
        valid[free_slot] <= 1'b1;
        next_seq         <= seq_inc;
      end
      if (commit_free) begin
        valid[hit_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cnt        <= '0;
      free_found <= 1'b0;
      hit_found  <= 1'b0;
      seq_found  <= 1'b0;
      used       <= '0;
      expired    <= '0;
      seq_cand   <= next_seq;
      seq_cnt    <= '0;
    end else begin
      if (cmd.scan && (cnt != CNT_END)) begin
        cnt <= cnt + CW'(1);
      end
      p_idx <= cnt[IW-1:0];
      if (p_valid) begin
        if (!v_p && !free_found) begin
          free_found <= 1'b1;
          free_slot  <= p_idx;
        end
        if (v_p && part_match) begin
          used[key_q[14 +: SQW]] <= 1'b1;
        end
        if (v_p && full_match && !hit_found) begin
          hit_found <= 1'b1;
          hit_idx   <= p_idx;
          hit_tag   <= tag_q;
          hit_bcast <= key_q[30];
        end
        if ((kind_r == KIND_TICK) && v_p && expire) begin
          expired <= expired + EXP_W'(1);
        end
      end
      if (cmd.seq_step) begin
        if (!used[seq_cand[SQW-1:0]]) begin
          seq_found <= 1'b1;
        end else begin
          seq_cand <= seq_inc;
          seq_cnt  <= seq_cnt + SQW'(1);
        end
      end
    end
  end

  assign st.in_pass    = (kind == KIND_SEND) && ((net_fn & RSP_NETFN_BIT) != 6'd0);
  assign st.in_none    = (kind == KIND_NONE);
  assign st.kind_send  = (kind_r == KIND_SEND);
  assign st.free_found = free_found;
  assign st.scan_done  = (cnt == CNT_END) && !p_valid;
  assign st.seq_free   = !used[seq_cand[SQW-1:0]];
  assign st.seq_last   = (seq_cnt == SCNT_MAX);
  assign st.out_busy   = out_valid && out_stall;

  // result
  logic [2:0]  r_status;
  logic [5:0]  r_seq;
  logic [31:0] r_tag;
  logic [15:0] r_port;
  logic [EXP_W-1:0] r_exp;

  always_comb begin
    r_status = ST_TICK;
    r_seq    = 6'd0;
    r_tag    = 32'd0;
    r_port   = 16'd0;
    r_exp    = '0;
    unique case (kind_r)
      KIND_SEND: begin
        if (pass_r) begin
          r_status = ST_PASS;
          r_seq    = seq_r;
        end else if (!free_found) begin
          r_status = ST_NO_ENTRY;
        end else if (!seq_found) begin
          r_status = ST_NO_SEQ;
        end else begin
          r_status = ST_ACCEPTED;
          r_seq    = seq_cand;
        end
      end
      KIND_RSP: begin
        r_seq = seq_r;
        if (hit_found) begin
          r_status = ST_MATCHED;
          r_tag    = hit_tag[47:16];
          r_port   = hit_tag[15:0];
        end else begin
          r_status = ST_UNMATCHED;
        end
      end
      KIND_TICK, KIND_NONE: begin
        r_status = ST_TICK;
        r_exp    = expired;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status        <= r_status;
      seq_out       <= r_seq;
      tag_out       <= r_tag;
      port_out      <= r_port;
      expired_count <= r_exp;
    end
  end

endmodule

// ===== rtl/ipt_ctrl.sv =====
// ----------------------------------------------------------------------------
// IPMB tracker controller
// Sequences accept, table scan, sequence search, commit and result load.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ipmb_pending_request_tracker_defines.svh"

module ipt_ctrl import ipt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  ipt_stat_t st,
  output ipt_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_SEQ    = 5'b00100,
    S_COMMIT = 5'b01000,
    S_OUT    = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        cmd.start = accept;
        if (accept) begin
          state_next = (st.in_pass || st.in_none) ? S_OUT : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (st.scan_done) begin
          state_next = (st.kind_send && st.free_found) ? S_SEQ : S_COMMIT;
        end
      end
      S_SEQ: begin
        cmd.seq_step = 1'b1;
        if (st.seq_free || st.seq_last) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!st.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `IPT_ASSERT(a_accept_leaves_idle, accept |=> (state != S_IDLE), "accept stayed idle")
  `IPT_ASSERT(a_seq_only_send, (state == S_SEQ) |-> st.kind_send, "seq search on non-send")
  `IPT_ASSERT(a_commit_then_out, (state == S_COMMIT) |=> (state == S_OUT), "commit not followed by output")
  `IPT_ASSERT_ALWAYS(a_load_not_stalled, cmd.load_out |-> !st.out_busy, "result load over held result")

endmodule

// ===== rtl/ipmb_pending_request_tracker.sv =====
// ----------------------------------------------------------------------------
// IPMB pending request tracker
// Table of outstanding IPMB requests with sequence number allocation,
// response matching and timer expiry.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------------
//  in      | in_valid / in_stall   | kind slave_addr lun net_fn command
//          |                       | seq_in timeout_ms msg_tag reply_port
//  out     | out_valid / out_stall | status seq_out tag_out port_out
//          |                       | expired_count
//  cfg     | cfg_we                | cfg_index cfg_data
//
//  Response and tick items scan the table one entry per cycle through the
//  one read port of each table RAM before out_valid rises. A request with a
//  free entry adds a sequence search, one candidate per cycle. Pass-through
//  and unused kinds skip the scan and go straight to the result load.
//  One item in flight; in_stall drops the cycle after the result is loaded.
//  Reset clears all valid bits at once; no clearing pass.
//  A stalled result holds the next result in the final state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ipmb_pending_request_tracker import ipt_pkg::*; #(
  parameter int NUM_ENTRIES = NUM_ENTRIES_DEF,
  parameter int SEQ_COUNT   = SEQ_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [7:0]  slave_addr,
  input  logic [1:0]  lun,
  input  logic [5:0]  net_fn,
  input  logic [7:0]  command,
  input  logic [5:0]  seq_in,
  input  logic [15:0] timeout_ms,
  input  logic [31:0] msg_tag,
  input  logic [15:0] reply_port,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [5:0]  seq_out,
  output logic [31:0] tag_out,
  output logic [15:0] port_out,
  output logic [8:0]  expired_count
);

  ipt_cmd_t  cmd;
  ipt_stat_t st;

  ipt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .st(st), .cmd(cmd)
  );

  ipt_datapath #(.NUM_ENTRIES(NUM_ENTRIES), .SEQ_COUNT(SEQ_COUNT)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .st(st),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .kind(kind), .slave_addr(slave_addr), .lun(lun), .net_fn(net_fn),
    .command(command), .seq_in(seq_in), .timeout_ms(timeout_ms),
    .msg_tag(msg_tag), .reply_port(reply_port),
    .out_stall(out_stall), .out_valid(out_valid), .status(status),
    .seq_out(seq_out), .tag_out(tag_out), .port_out(port_out),
    .expired_count(expired_count)
  );

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// IPMB pending request tracker testbench
// Directed, table-exhaustion and random request/response/tick traffic with
// random idling on both channels. Every result is checked against an
// in-bench model of the request table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import ipt_pkg::*;

  localparam int ENTRIES = NUM_ENTRIES_DEF;
  localparam int SEQS    = SEQ_COUNT_DEF;

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  sa;
    logic [1:0]  lun;
    logic [5:0]  nf;
    logic [7:0]  cmd;
    logic [5:0]  seq;
    logic [15:0] tmo;
    logic [31:0] tag;
    logic [15:0] port;
  } ipmb_item_t;

  typedef struct {
    logic [2:0]  status;
    logic [5:0]  seq;
    logic [31:0] tag;
    logic [15:0] port;
    logic [8:0]  expired;
  } tracker_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  kind = '0;
  logic [7:0]  slave_addr = '0;
  logic [1:0]  lun = '0;
  logic [5:0]  net_fn = '0;
  logic [7:0]  command = '0;
  logic [5:0]  seq_in = '0;
  logic [15:0] timeout_ms = '0;
  logic [31:0] msg_tag = '0;
  logic [15:0] reply_port = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [5:0]  seq_out;
  logic [31:0] tag_out;
  logic [15:0] port_out;
  logic [8:0]  expired_count;

  ipmb_pending_request_tracker i_dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("FAIL");
    $finish;
  end

  // model of the request table
  bit          tbl_valid [ENTRIES];
  logic [29:0] tbl_key   [ENTRIES];
  logic [47:0] tbl_tag   [ENTRIES];
  logic [15:0] tbl_timer [ENTRIES];
  bit          tbl_bcast [ENTRIES];
  logic [5:0]  seq_ptr = '0;
  logic [15:0] lim_reg = TIMEOUT_LIMIT_RST;
  logic [15:0] dflt_reg = DEFAULT_TIMEOUT_RST;
  logic [15:0] period_reg = TICK_PERIOD_RST;
  logic [7:0]  bcast_reg = BROADCAST_ADDR_RST;

  tracker_result_t pending_results[$];
  int errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  function automatic logic [29:0] req_key(ipmb_item_t it, logic [5:0] s);
    return {it.sa, it.lun, s, it.nf & REQ_NETFN_MASK, it.cmd};
  endfunction

  function automatic int lookup_entry(logic [29:0] key);
    for (int i = 0; i < ENTRIES; i++)
      if (tbl_valid[i] && tbl_key[i] == key) return i;
    return -1;
  endfunction

  function automatic tracker_result_t track_item(ipmb_item_t it);
    tracker_result_t r;
    int slot;
    int hit;
    logic [15:0] t;
    logic [5:0] s;
    bit found;
    r = '{ST_TICK, '0, '0, '0, '0};
    slot = -1;
    found = 1'b0;
    s = '0;
    case (it.kind)
      KIND_SEND: begin
        if ((it.nf & RSP_NETFN_BIT) != 6'd0) begin
          r.status = ST_PASS;
          r.seq = it.seq;
        end else begin
          t = (it.tmo > lim_reg) ? lim_reg : it.tmo;
          if (t == 16'd0) t = dflt_reg;
          for (int i = 0; i < ENTRIES; i++)
            if (!tbl_valid[i]) begin
              slot = i;
              break;
            end
          if (slot < 0) begin
            r.status = ST_NO_ENTRY;
          end else begin
            for (int k = 0; k < SEQS; k++) begin
              s = 6'((int'(seq_ptr) + k) % SEQS);
              if (lookup_entry(req_key(it, s)) < 0) begin
                found = 1'b1;
                break;
              end
            end
            if (!found) begin
              r.status = ST_NO_SEQ;
            end else begin
              tbl_valid[slot] = 1'b1;
              tbl_key[slot] = req_key(it, s);
              tbl_tag[slot] = {it.tag, it.port};
              tbl_timer[slot] = t;
              tbl_bcast[slot] = (it.sa == bcast_reg);
              seq_ptr = 6'((int'(s) + 1) % SEQS);
              r.status = ST_ACCEPTED;
              r.seq = s;
            end
          end
        end
      end
      KIND_RSP: begin
        hit = lookup_entry(req_key(it, it.seq));
        r.seq = it.seq;
        if (hit < 0) begin
          r.status = ST_UNMATCHED;
        end else begin
          r.status = ST_MATCHED;
          {r.tag, r.port} = tbl_tag[hit];
          if (!tbl_bcast[hit]) tbl_valid[hit] = 1'b0;
        end
      end
      KIND_TICK: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (!tbl_valid[i]) continue;
          if (tbl_timer[i] <= period_reg) begin
            tbl_valid[i] = 1'b0;
            r.expired++;
          end else begin
            tbl_timer[i] -= period_reg;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // one input transfer; leaves in_valid high for a back-to-back follow-up
  task automatic send_item(ipmb_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= it.kind;
    slave_addr <= it.sa;
    lun <= it.lun;
    net_fn <= it.nf;
    command <= it.cmd;
    seq_in <= it.seq;
    timeout_ms <= it.tmo;
    msg_tag <= it.tag;
    reply_port <= it.port;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(track_item(it));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_TIMEOUT_LIMIT:   lim_reg = val;
      REG_DEFAULT_TIMEOUT: dflt_reg = val;
      REG_TICK_PERIOD:     period_reg = val;
      default:             bcast_reg = val[7:0];
    endcase
  endtask

  task automatic set_regs(logic [15:0] lim, logic [15:0] dflt, logic [15:0] per,
                          logic [7:0] bc);
    drain();
    write_reg(REG_TIMEOUT_LIMIT, lim);
    write_reg(REG_DEFAULT_TIMEOUT, dflt);
    write_reg(REG_TICK_PERIOD, per);
    write_reg(REG_BROADCAST_ADDR, {8'h00, bc});
  endtask

  function automatic ipmb_item_t rand_item(logic [1:0] k);
    ipmb_item_t it;
    it.kind = k;
    it.sa = 8'($urandom());
    it.lun = 2'($urandom());
    it.nf = 6'($urandom());
    it.cmd = 8'($urandom());
    it.seq = 6'($urandom());
    it.tmo = 16'($urandom());
    it.tag = $urandom();
    it.port = 16'($urandom());
    return it;
  endfunction

  task automatic test_directed();
    ipmb_item_t it;
    it = rand_item(KIND_SEND);
    // broadcast request with default timeout, matched twice
    it.sa = bcast_reg; it.lun = '0; it.nf = '0; it.cmd = '0; it.tmo = '0;
    it.tag = '0; it.port = '0;
    send_item(it);
    it.kind = KIND_RSP; it.seq = '0; it.nf = 6'h01;
    send_item(it);
    send_item(it);
    // all-ones request, timeout clamped
    it = '{KIND_SEND, 8'hFF, 2'h3, 6'h3E, 8'hFF, 6'h3F, 16'hFFFF, '1, '1};
    send_item(it);
    it.kind = KIND_RSP; it.nf = 6'h3F; it.seq = 6'd1;
    send_item(it);
    send_item(it);  // already freed
    // odd netfn send passes through
    it = rand_item(KIND_SEND); it.nf = 6'h3F; it.seq = 6'h3F;
    send_item(it);
    it.nf = 6'h01; it.seq = '0;
    send_item(it);
    // unused kind
    send_item(rand_item(KIND_NONE));
    it = rand_item(KIND_NONE); it = '{KIND_NONE, '1, '1, '1, '1, '1, '1, '1, '1};
    send_item(it);
    // timer equal to the period expires, one above survives one tick
    it = rand_item(KIND_SEND); it.nf = 6'h06; it.tmo = period_reg;
    send_item(it);
    it.tmo = period_reg + 16'd1; it.cmd = it.cmd + 8'd1;
    send_item(it);
    send_item(rand_item(KIND_TICK));
    send_item(rand_item(KIND_TICK));
    send_item(rand_item(KIND_RSP));
  endtask

  // exhaust the sequence numbers of one key, then every table entry
  task automatic test_table_full();
    ipmb_item_t it;
    set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFE);
    send_item(rand_item(KIND_TICK));
    it = rand_item(KIND_SEND); it.nf = 6'h2C;
    for (int i = 0; i < SEQS + 1; i++) begin
      it.tag = $urandom();
      send_item(it);
    end
    for (int i = 0; i < ENTRIES - SEQS + 1; i++) begin
      it = rand_item(KIND_SEND);
      it.nf[0] = 1'b0;
      send_item(it);
    end
    send_item(rand_item(KIND_TICK));
  endtask

  task automatic test_random(int n);
    ipmb_item_t it;
    int r;
    int j;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 45) begin
        it = rand_item(KIND_SEND);
        // narrow key space so sequence search and matching see collisions
        if ($urandom_range(9) < 8) begin
          it.sa = ($urandom_range(4) == 0) ? bcast_reg : 8'($urandom_range(3));
          it.lun = 2'($urandom_range(1));
          it.nf = {3'($urandom_range(2)), 3'b000};
          it.cmd = 8'($urandom_range(2));
        end
        case ($urandom_range(3))
          0: it.tmo = '0;
          1: it.tmo = 16'($urandom_range(1, 3 * int'(period_reg)));
          default: ;
        endcase
      end else if (r < 80) begin
        it = rand_item(KIND_RSP);
        j = $urandom_range(ENTRIES - 1);
        if ($urandom_range(9) < 8) begin
          for (int k = 0; k < ENTRIES; k++)
            if (tbl_valid[(j + k) % ENTRIES]) begin
              j = (j + k) % ENTRIES;
              {it.sa, it.lun, it.seq, it.nf, it.cmd} = tbl_key[j];
              it.nf[0] = 1'($urandom());
              break;
            end
        end
      end else if (r < 95) begin
        it = rand_item(KIND_TICK);
      end else begin
        it = rand_item($urandom_range(1) ? KIND_NONE : KIND_SEND);
        it.nf[0] = 1'b1;
      end
      send_item(it);
    end
  endtask

  // stall on the result side
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    tracker_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transfer, status %0d", status);
      end else begin
        e = pending_results.pop_front();
        if (status !== e.status || seq_out !== e.seq || tag_out !== e.tag ||
            port_out !== e.port || expired_count !== e.expired) begin
          errors++;
          if (errors <= 10)
            $display({"mismatch: exp st %0d seq %0d tag %h port %h exp %0d,",
                      " got st %0d seq %0d tag %h port %h exp %0d"},
                     e.status, e.seq, e.tag, e.port, e.expired,
                     status, seq_out, tag_out, port_out, expired_count);
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    idle_pct = 34;
    stall_pct = 83;
    test_directed();
    test_random(80);
    drain();  // sender holds off until all results are back
    test_random(70);
    idle_pct = 83;
    stall_pct = 34;
    set_regs(16'd1, 16'd1, 16'd1, 8'hFF);
    test_random(130);
    test_table_full();
    idle_pct = 0;
    stall_pct = 0;
    set_regs(16'd300, 16'd50, 16'd40, 8'($urandom_range(3)));
    test_random(140);
    drain();
    repeat (400) @(posedge clk);
    // results left over are failures
    if (errors == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ipt_pkg.sv
rtl/ipt_ram.sv
rtl/ipt_datapath.sv
rtl/ipt_ctrl.sv
rtl/ipmb_pending_request_tracker.sv
dv/testbench.sv
